@@ sv/ese_pkg.sv @@
// Shared types and constants of the escape sequence expander.
// Holds the port payload structs, the decode command passed from front to back,
// and the queue sizing. Depends on nothing.
`default_nettype none

package ese_pkg;

	// Depth of the command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Error codes carried in err_code
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_BROKEN_ESC = 3'd1;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
	localparam logic [2:0] ERR_BAD_DIGIT  = 3'd3;
	localparam logic [2:0] ERR_UNENCODABLE = 3'd4;
	localparam logic [2:0] ERR_NO_HEX     = 3'd5;
	localparam logic [2:0] ERR_UNKNOWN    = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] err_code;
		logic       run_last;
		logic       string_done;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_ERR,
		CMD_UTF8
	} cmd_kind_t;

	// One decoded action; the back end turns it into one to four results
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;       // plain byte for CMD_BYTE
		logic [2:0]  err;        // error code for CMD_ERR
		logic [20:0] code_point; // code point for CMD_UTF8
		logic [1:0]  last_idx;   // UTF-8 length minus one
		logic        str_end;    // input byte was the last of its string
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_HEX,
		MODE_DROP
	} mode_t;

endpackage

`default_nettype wire

@@ sv/ese_front.sv @@
// Front end of the escape sequence expander: decode state machine.
// Classifies each accepted byte and pushes a command when it yields results.
// Depends on ese_pkg.
`default_nettype none

module ese_front
	import ese_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output logic          cmd_valid,
	output cmd_t          cmd
);

	mode_t       mode_q, mode_d;
	logic [3:0]  wanted_q, wanted_d;
	logic [3:0]  seen_q, seen_d;
	logic [31:0] value_q, value_d;
	logic        bad_q, bad_d;
	logic        hexbyte_q, hexbyte_d;

	logic        nib_ok;
	logic [3:0]  nib;
	logic [3:0]  seen_inc;
	logic [31:0] value_inc;
	logic        bad_inc;
	logic [7:0]  b;
	logic        last;

	always_comb begin
		b      = item.in_byte;
		last   = item.string_end;
		nib_ok = 1'b1;
		nib    = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			nib = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			nib = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			nib = 4'(b - 8'h37);
		end else begin
			nib_ok = 1'b0;
		end
		seen_inc  = seen_q + 4'd1;
		value_inc = nib_ok ? {value_q[27:0], nib} : value_q;
		bad_inc   = bad_q | ~nib_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TEXT;
			wanted_q  <= '0;
			seen_q    <= '0;
			value_q   <= '0;
			bad_q     <= 1'b0;
			hexbyte_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			wanted_q  <= wanted_d;
			seen_q    <= seen_d;
			value_q   <= value_d;
			bad_q     <= bad_d;
			hexbyte_q <= hexbyte_d;
		end
	end

	always_comb begin
		mode_d         = mode_q;
		wanted_d       = wanted_q;
		seen_d         = seen_q;
		value_d        = value_q;
		bad_d          = bad_q;
		hexbyte_d      = hexbyte_q;
		cmd_valid      = 1'b0;
		cmd.kind       = CMD_BYTE;
		cmd.data       = b;
		cmd.err        = ERR_NONE;
		cmd.code_point = '0;
		cmd.last_idx   = 2'd0;
		cmd.str_end    = last;

		unique case (mode_q)
			MODE_TEXT: begin
				if (b == 8'h5C) begin
					if (last) begin
						cmd_valid = 1'b1;
						cmd.kind  = CMD_ERR;
						cmd.err   = ERR_BROKEN_ESC;
					end else begin
						mode_d = MODE_ESC;
					end
				end else begin
					cmd_valid = 1'b1;
				end
			end
			MODE_ESC: begin
				mode_d    = MODE_TEXT;
				cmd_valid = 1'b1;
				case (b)
					8'h5C, 8'h22: cmd.data = b;
					8'h6E: cmd.data = 8'h0A;
					8'h72: cmd.data = 8'h0D;
					8'h74: cmd.data = 8'h09;
					8'h75, 8'h55: begin
						if (last) begin
							cmd.kind = CMD_ERR;
							cmd.err  = ERR_INCOMPLETE;
						end else begin
							// start collecting hex digits of a code point
							cmd_valid = 1'b0;
							mode_d    = MODE_HEX;
							wanted_d  = (b == 8'h75) ? 4'd4 : 4'd8;
							seen_d    = '0;
							value_d   = '0;
							bad_d     = 1'b0;
							hexbyte_d = 1'b0;
						end
					end
					8'h78: begin
						if (last) begin
							cmd.kind = CMD_ERR;
							cmd.err  = ERR_NO_HEX;
						end else begin
							cmd_valid = 1'b0;
							mode_d    = MODE_HEX;
							wanted_d  = 4'd2;
							seen_d    = '0;
							value_d   = '0;
							bad_d     = 1'b0;
							hexbyte_d = 1'b1;
						end
					end
					default: begin
						cmd.kind = CMD_ERR;
						cmd.err  = ERR_UNKNOWN;
						mode_d   = last ? MODE_TEXT : MODE_DROP;
					end
				endcase
			end
			MODE_HEX: begin
				if (seen_inc < wanted_q && !last) begin
					// hold: more digits to come
					seen_d  = seen_inc;
					value_d = value_inc;
					bad_d   = bad_inc;
				end else begin
					cmd_valid = 1'b1;
					mode_d    = MODE_TEXT;
					wanted_d  = '0;
					seen_d    = '0;
					value_d   = '0;
					bad_d     = 1'b0;
					hexbyte_d = 1'b0;
					if (seen_inc < wanted_q && !hexbyte_q) begin
						cmd.kind = CMD_ERR;
						cmd.err  = ERR_INCOMPLETE;
					end else if (bad_inc) begin
						cmd.kind = CMD_ERR;
						cmd.err  = ERR_BAD_DIGIT;
						mode_d   = last ? MODE_TEXT : MODE_DROP;
					end else if (hexbyte_q) begin
						cmd.data = value_inc[7:0];
					end else if (value_inc >= 32'h0011_0000) begin
						cmd.kind = CMD_ERR;
						cmd.err  = ERR_UNENCODABLE;
						mode_d   = last ? MODE_TEXT : MODE_DROP;
					end else begin
						cmd.kind       = CMD_UTF8;
						cmd.code_point = value_inc[20:0];
						if (value_inc < 32'h80) begin
							cmd.last_idx = 2'd0;
						end else if (value_inc < 32'h800) begin
							cmd.last_idx = 2'd1;
						end else if (value_inc < 32'h1_0000) begin
							cmd.last_idx = 2'd2;
						end else begin
							cmd.last_idx = 2'd3;
						end
					end
				end
			end
			MODE_DROP: begin
				if (last) begin
					mode_d = MODE_TEXT;
				end
			end
			default: mode_d = MODE_TEXT;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/ese_fifo.sv @@
// Short command queue between the decode front end and the output back end.
// Register array with read and write pointers and an occupancy count.
// Depends on ese_pkg.
`default_nettype none

module ese_fifo
	import ese_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      not_full,
	input  wire logic pop,
	output logic      not_empty,
	output cmd_t      head
);

	cmd_t                  entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign not_full  = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/ese_back.sv @@
// Back end of the escape sequence expander. Depends on ese_pkg. Expands
// queued commands into registered results, one per cycle unless stalled.
`default_nettype none

module ese_back
	import ese_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       load;
	logic       last_res;
	logic [1:0] shift;
	logic [5:0] chunk;
	out_item_t  res;

	always_comb begin
		shift = cmd.last_idx - idx_q;
		case (shift)
			2'd0:    chunk = cmd.code_point[5:0];
			2'd1:    chunk = cmd.code_point[11:6];
			2'd2:    chunk = cmd.code_point[17:12];
			default: chunk = {3'b000, cmd.code_point[20:18]};
		endcase

		last_res = (cmd.kind != CMD_UTF8) || (idx_q == cmd.last_idx);

		res.err_code    = ERR_NONE;
		res.run_last    = last_res;
		res.string_done = cmd.str_end && last_res;
		unique case (cmd.kind)
			CMD_BYTE: res.out_byte = cmd.data;
			CMD_ERR: begin
				res.out_byte    = 8'h00;
				res.err_code    = cmd.err;
				res.string_done = 1'b1;
			end
			CMD_UTF8: begin
				if (idx_q != 2'd0) begin
					res.out_byte = {2'b10, chunk};
				end else begin
					unique case (cmd.last_idx)
						2'd0: res.out_byte = {1'b0, cmd.code_point[6:0]};
						2'd1: res.out_byte = {3'b110, cmd.code_point[10:6]};
						2'd2: res.out_byte = {4'b1110, cmd.code_point[15:12]};
						default: res.out_byte = {5'b11110, cmd.code_point[20:18]};
					endcase
				end
			end
			default: res.out_byte = 8'h00;
		endcase
	end

	assign load      = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop   = load && last_res;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= last_res ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/escape_sequence_expander_top.sv @@
// Escape sequence expander: backslash escapes to bytes, code points to UTF-8.
// Each command is written into the queue, then loaded into the output register
// that drives out_valid. Reset clears all control state at once.
// Throughput: one input byte per cycle while the four-entry command queue has
// room; the output register drains one result per cycle while out_ready is
// high, so a UTF-8 code point takes one to four results.
`default_nettype none

module escape_sequence_expander_top
	import ese_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	logic accept;
	logic front_valid;
	cmd_t front_cmd;
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;
	cmd_t q_head;

	// Take a new request whenever the queue has room; the decode state
	// advances on every accepted byte, whether or not it yields a command.
	assign in_ready = q_not_full;
	assign accept   = in_valid && q_not_full;

	ese_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	// Decouple decoding from output so UTF-8 bursts stall input only once it fills.
	ese_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && front_valid),
		.push_data (front_cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Expand the head command and hold each result until taken.
	ese_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for escape_sequence_expander_top: backslash escapes, hex escapes
// and UTF-8 encoding of code points, checked result by result against a local predictor.
// Depends on ese_pkg and the escape_sequence_expander_top RTL only.

module tb_top;
	import ese_pkg::*;

	// Byte values of the characters the decoder reacts to
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_UPPER_U   = 8'h55;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] BYTE_LF      = 8'h0A;
	localparam logic [7:0] BYTE_CR      = 8'h0D;
	localparam logic [7:0] BYTE_TAB     = 8'h09;

	// Digit counts of the three hex escapes
	localparam logic [3:0] SHORT_CP_DIGITS = 4'd4;
	localparam logic [3:0] LONG_CP_DIGITS  = 4'd8;
	localparam logic [3:0] RAW_BYTE_DIGITS = 4'd2;

	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_IDLE     = 17;
	localparam int REPORT_LIMIT = 10;

	// Value of a hex digit character, -1 for anything else
	function automatic int hex_nibble(logic [7:0] b);
		if (b >= CH_ZERO && b <= CH_NINE) return b - CH_ZERO;
		if (b >= CH_LOWER_A && b <= CH_LOWER_F) return b - CH_LOWER_A + 10;
		if (b >= CH_UPPER_A && b <= CH_UPPER_F) return b - CH_UPPER_A + 10;
		return -1;
	endfunction

	// Tracks the decoder state, expands each accepted request into the bytes it
	// should produce, and compares those against the results coming out.
	class utf8_escape_tracker;
		mode_t       mode = MODE_TEXT;
		logic [3:0]  wanted = '0;
		logic [3:0]  seen = '0;
		logic [31:0] code = '0;
		bit          bad_digit = 1'b0;
		bit          byte_escape = 1'b0;
		out_item_t   expected_results[$];
		int          bad_results = 0;

		function void push_result(logic [7:0] b, logic [2:0] e, bit last, bit done);
			out_item_t r;
			r.out_byte = b;
			r.err_code = e;
			r.run_last = last;
			r.string_done = done;
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void clear_digits();
			wanted = '0;
			seen = '0;
			code = '0;
			bad_digit = 1'b0;
			byte_escape = 1'b0;
		endfunction

		function void raise_error(logic [2:0] e, bit fin);
			clear_digits();
			mode = fin ? MODE_TEXT : MODE_DROP;
			push_result(8'h00, e, 1'b1, 1'b1);
		endfunction

		function void emit_plain(logic [7:0] b, bit fin);
			mode = MODE_TEXT;
			push_result(b, ERR_NONE, 1'b1, fin);
		endfunction

		function void open_digits(logic [3:0] count, bit raw);
			clear_digits();
			wanted = count;
			byte_escape = raw;
			mode = MODE_HEX;
		endfunction

		// All digits in (or the string ended): emit the raw byte or the UTF-8 form
		function void close_digits(bit fin);
			logic [31:0] v;
			logic [7:0]  enc [4];
			int          n;
			v = code;
			if (bad_digit) begin
				raise_error(ERR_BAD_DIGIT, fin);
				return;
			end
			if (byte_escape) begin
				clear_digits();
				emit_plain(v[7:0], fin);
				return;
			end
			if (v < 32'h80) begin
				n = 1;
				enc[0] = v[7:0];
			end else if (v < 32'h800) begin
				n = 2;
				enc[0] = {3'b110, v[10:6]};
				enc[1] = {2'b10, v[5:0]};
			end else if (v < 32'h10000) begin
				n = 3;
				enc[0] = {4'b1110, v[15:12]};
				enc[1] = {2'b10, v[11:6]};
				enc[2] = {2'b10, v[5:0]};
			end else if (v < 32'h110000) begin
				n = 4;
				enc[0] = {5'b11110, v[20:18]};
				enc[1] = {2'b10, v[17:12]};
				enc[2] = {2'b10, v[11:6]};
				enc[3] = {2'b10, v[5:0]};
			end else begin
				raise_error(ERR_UNENCODABLE, fin);
				return;
			end
			clear_digits();
			mode = MODE_TEXT;
			for (int i = 0; i < n; i++)
				push_result(enc[i], ERR_NONE, i == n - 1, fin && i == n - 1);
		endfunction

		// Advance the decoder by one accepted request; returns 0 if it was dropped
		function bit note_request(in_item_t req);
			logic [7:0] b;
			bit         fin;
			bit         live;
			int         nib;
			b = req.in_byte;
			fin = req.string_end;
			live = (mode != MODE_DROP);
			case (mode)
				MODE_TEXT: begin
					if (b != CH_BACKSLASH)
						emit_plain(b, fin);
					else if (fin)
						raise_error(ERR_BROKEN_ESC, 1'b1);
					else
						mode = MODE_ESC;
				end
				MODE_ESC: begin
					case (b)
						CH_BACKSLASH: emit_plain(CH_BACKSLASH, fin);
						CH_QUOTE:     emit_plain(CH_QUOTE, fin);
						CH_N:         emit_plain(BYTE_LF, fin);
						CH_R:         emit_plain(BYTE_CR, fin);
						CH_T:         emit_plain(BYTE_TAB, fin);
						CH_LOWER_U, CH_UPPER_U: begin
							if (fin)
								raise_error(ERR_INCOMPLETE, 1'b1);
							else
								open_digits(b == CH_LOWER_U ? SHORT_CP_DIGITS : LONG_CP_DIGITS,
									1'b0);
						end
						CH_X: begin
							if (fin)
								raise_error(ERR_NO_HEX, 1'b1);
							else
								open_digits(RAW_BYTE_DIGITS, 1'b1);
						end
						default: raise_error(ERR_UNKNOWN, fin);
					endcase
				end
				MODE_HEX: begin
					nib = hex_nibble(b);
					if (nib < 0)
						bad_digit = 1'b1;
					else
						code = {code[27:0], nib[3:0]};
					seen = seen + 4'd1;
					// Short of digits and more to come: just hold
					if (!(seen < wanted && !fin)) begin
						if (seen < wanted && !byte_escape)
							raise_error(ERR_INCOMPLETE, 1'b1);
						else
							close_digits(fin);
					end
				end
				default: begin
					if (fin)
						mode = MODE_TEXT;
				end
			endcase
			return live;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_LIMIT)
					$display("%0t: unexpected result byte %02h err %0d last %0d done %0d",
						$time, got.out_byte, got.err_code, got.run_last, got.string_done);
				return;
			end
			want = expected_results.pop_front();
			if (got.out_byte !== want.out_byte || got.err_code !== want.err_code ||
					got.run_last !== want.run_last || got.string_done !== want.string_done) begin
				bad_results++;
				if (bad_results <= REPORT_LIMIT)
					$display("%0t: bad result, expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
						$time, want.out_byte, want.err_code, want.run_last, want.string_done,
						got.out_byte, got.err_code, got.run_last, got.string_done);
			end
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function int failures();
			return bad_results + expected_results.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	utf8_escape_tracker tracker;
	logic [7:0]         str_bytes[$];   // bytes of the string being built
	int                 live_items;     // requests not swallowed after an error
	bit                 tx_steady;      // sender runs without gaps
	bit                 rx_steady;      // receiver runs without stalls

	// Append one byte to the string being built
	function automatic void add_byte(logic [7:0] c);
		str_bytes.insert(str_bytes.size(), c);
	endfunction

	escape_sequence_expander_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("escape_sequence_expander_top: mismatch");
		$finish;
	end

	// Check every result request taken by the receiver, in order
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(out_data);
	end

	// Offer one request, after a random gap unless tx_steady, and hold it until it is taken
	task automatic send_byte(logic [7:0] b, bit fin);
		in_item_t req;
		int       gap;
		req.in_byte = b;
		req.string_end = fin;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		if (tracker.note_request(req))
			live_items++;
	endtask

	// Send the built string, flagging its last byte
	task automatic send_string();
		foreach (str_bytes[i])
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
	endtask

	task automatic send_text(string s);
		str_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
		send_string();
	endtask

	// Drop valid and hold the sender until the block has delivered everything owed
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	// Receiver: stall for a random gap unless rx_steady, then take one result
	task automatic take_results();
		int gap;
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_steady = !rx_steady;
			gap = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 10) return CH_ZERO + nib;
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + nib - 8'd10;
	endfunction

	function automatic void append_hex(logic [31:0] v, int digits);
		for (int i = digits - 1; i >= 0; i--)
			add_byte(hex_char(v[4 * i +: 4]));
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
		return c;
	endfunction

	// Code point for a four-digit escape: one- to three-byte UTF-8 lengths, surrogates, edges
	function automatic logic [31:0] short_code_point();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 'h7F);
			1: return $urandom_range('h80, 'h7FF);
			2: return $urandom_range('h800, 'hFFFF);
			3: return $urandom_range('hD800, 'hDFFF);
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h0;
					1: return 32'h7F;
					2: return 32'h80;
					3: return 32'h7FF;
					4: return 32'h800;
					default: return 32'hFFFF;
				endcase
			end
		endcase
	endfunction

	// Code point for an eight-digit escape, including values too big to encode
	function automatic logic [31:0] long_code_point();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 'h7FF);
			1: return $urandom_range('h800, 'hFFFF);
			2, 3: return $urandom_range('h10000, 'h10FFFF);
			4: return $urandom_range('h110000, 32'hFFFF_FFFF);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h10000;
					1: return 32'h10FFFF;
					2: return 32'h110000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	// Build one string, mostly well-formed escapes around random text, with some
	// broken escapes and now and then a cut-off tail
	task automatic send_random_string();
		int         parts;
		int         pick;
		int         slot;
		logic [7:0] digits [8];
		str_bytes.delete();
		parts = $urandom_range(1, 5);
		for (int p = 0; p < parts; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 50) begin
				add_byte(CH_BACKSLASH);
				case ($urandom_range(0, 4))
					0: add_byte(CH_BACKSLASH);
					1: add_byte(CH_QUOTE);
					2: add_byte(CH_N);
					3: add_byte(CH_R);
					default: add_byte(CH_T);
				endcase
			end else if (pick < 64) begin
				add_byte(CH_BACKSLASH);
				add_byte(CH_LOWER_U);
				append_hex(short_code_point(), SHORT_CP_DIGITS);
			end else if (pick < 77) begin
				add_byte(CH_BACKSLASH);
				add_byte(CH_UPPER_U);
				append_hex(long_code_point(), LONG_CP_DIGITS);
			end else if (pick < 87) begin
				add_byte(CH_BACKSLASH);
				add_byte(CH_X);
				// At the end of the string a single digit is allowed
				if (p == parts - 1 && $urandom_range(0, 2) == 0)
					append_hex($urandom_range(0, 15), 1);
				else
					append_hex($urandom_range(0, 255), RAW_BYTE_DIGITS);
			end else if (pick < 93) begin
				// Backslash followed by anything at all
				add_byte(CH_BACKSLASH);
				add_byte(8'($urandom_range(0, 255)));
			end else begin
				// Hex escape with one non-hex byte among its digits
				add_byte(CH_BACKSLASH);
				case ($urandom_range(0, 2))
					0: begin
						add_byte(CH_LOWER_U);
						slot = SHORT_CP_DIGITS;
					end
					1: begin
						add_byte(CH_UPPER_U);
						slot = LONG_CP_DIGITS;
					end
					default: begin
						add_byte(CH_X);
						slot = RAW_BYTE_DIGITS;
					end
				endcase
				for (int i = 0; i < slot; i++)
					digits[i] = hex_char(4'($urandom_range(0, 15)));
				digits[$urandom_range(0, slot - 1)] = non_hex_byte();
				for (int i = 0; i < slot; i++)
					add_byte(digits[i]);
			end
		end
		if (str_bytes.size() > 1 && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, str_bytes.size() - 1)) void'(str_bytes.pop_back());
		send_string();
	endtask

	initial begin
		int strings_sent;
		tracker = new;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		arst_n <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		live_items = 0;
		strings_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: extreme bytes, some escape letters, every error but ERR_UNENCODABLE
		str_bytes = '{8'h00, CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_T,
			CH_BACKSLASH, CH_QUOTE, 8'hFF};
		send_string();
		send_text("\\");        // backslash as last byte
		send_text("\\qz");      // unknown letter, then a swallowed last byte
		send_text("\\u");       // code point escape ending the string
		send_text("\\x");       // byte escape ending the string
		send_text("\\x-");      // one bad digit at the end of the string
		send_text("\\u-1");     // too few digits wins over the bad one
		send_text("\\xF");      // single digit at the end of the string
		send_text("\\uD800");   // surrogate, encoded as three bytes

		// Pause the sender until the block has caught up
		drain();

		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			send_random_string();
			strings_sent++;
			if (strings_sent % 40 == 0)
				drain();
		end
		tx_steady = 1'b0;

		// Wait for the last results, then give the pipeline time to show extras
		drain();
		repeat (20) @(posedge clk);
		if (tracker.failures() == 0)
			$display("escape_sequence_expander_top: match");
		else
			$display("escape_sequence_expander_top: mismatch");
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		take_results();
	end

endmodule
